// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the CSD decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while reset is released.
`define SDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sdcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcsd_pkg
// Types, status codes and rate tables for the SD/MMC CSD decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcsd_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_BAD_CSD  = 2'd3
    } status_t;

    localparam logic [3:0] BLOCK_LEN_512 = 4'd9;

    typedef struct packed {
        logic [31:0] resp_word0;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
        logic [31:0] resp_word3;
        logic        is_mmc;
        logic        response_received;
        logic        long_response;
    } csd_req_t;

    typedef struct packed {
        status_t     status;
        logic [32:0] sector_count;
        logic [29:0] transfer_speed;
        logic [16:0] erase_sectors;
        logic        erase_valid;
    } csd_rsp_t;

    function automatic logic [23:0] rate_exp_value(input logic [2:0] code);
        logic [23:0] val;
        unique case (code)
            3'd0:    val = 24'd10000;
            3'd1:    val = 24'd100000;
            3'd2:    val = 24'd1000000;
            3'd3:    val = 24'd10000000;
            default: val = 24'd0;
        endcase
        return val;
    endfunction

    function automatic logic [6:0] rate_mant_value(input logic [3:0] code);
        logic [6:0] val;
        unique case (code)
            4'd0:    val = 7'd0;
            4'd1:    val = 7'd10;
            4'd2:    val = 7'd12;
            4'd3:    val = 7'd13;
            4'd4:    val = 7'd15;
            4'd5:    val = 7'd20;
            4'd6:    val = 7'd25;
            4'd7:    val = 7'd30;
            4'd8:    val = 7'd35;
            4'd9:    val = 7'd40;
            4'd10:   val = 7'd45;
            4'd11:   val = 7'd50;
            4'd12:   val = 7'd55;
            4'd13:   val = 7'd60;
            4'd14:   val = 7'd70;
            default: val = 7'd80;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdcsd_req_if.sv =====
// ----------------------------------------------------------------------------
// sdcsd_req_if
// Request channel: one CSD response image with its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdcsd_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic        is_mmc;
    logic        response_received;
    logic        long_response;

    modport source (
        output valid, resp_word0, resp_word1, resp_word2, resp_word3,
               is_mmc, response_received, long_response,
        input  ready
    );

    modport sink (
        input  valid, resp_word0, resp_word1, resp_word2, resp_word3,
               is_mmc, response_received, long_response,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sdcsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sdcsd_rsp_if
// Result channel: decoded capacity, speed and erase unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdcsd_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [32:0] sector_count;
    logic [29:0] transfer_speed;
    logic [16:0] erase_sectors;
    logic        erase_valid;

    modport source (
        output valid, status, sector_count, transfer_speed, erase_sectors, erase_valid,
        input  ready
    );

    modport sink (
        input  valid, status, sector_count, transfer_speed, erase_sectors, erase_valid,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sdcsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdcsd_in_stage
// Input register capturing one request transfer per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcsd_in_stage
    import sdcsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sdcsd_req_if.sink  req,
    input  wire logic  advance,
    output logic       stage_valid,
    output csd_req_t   stage_data
);

    logic     valid_reg;
    logic     valid_next;
    csd_req_t data_reg;
    logic     load;

    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.ready)
        begin
            valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.resp_word0        <= req.resp_word0;
            data_reg.resp_word1        <= req.resp_word1;
            data_reg.resp_word2        <= req.resp_word2;
            data_reg.resp_word3        <= req.resp_word3;
            data_reg.is_mmc            <= req.is_mmc;
            data_reg.response_received <= req.response_received;
            data_reg.long_response     <= req.long_response;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/sdcsd_decode.sv =====
// ----------------------------------------------------------------------------
// sdcsd_decode
// Combinational decode of one CSD image into capacity, speed and erase unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcsd_decode
    import sdcsd_pkg::*;
(
    input  wire csd_req_t req_data,
    output csd_rsp_t      rsp_data
);

    logic [127:0] csd;
    logic [1:0]   structure;
    logic [11:0]  c_size_v1;
    logic [2:0]   c_size_mult;
    logic [3:0]   read_bl_len;
    logic [21:0]  c_size_v2;
    logic [3:0]   write_bl_len;
    logic [12:0]  v1_base;
    logic [3:0]   v1_shift;
    logic [32:0]  v1_sectors;
    logic [32:0]  v2_sectors;
    logic [29:0]  speed_full;
    logic [7:0]   sd_group;
    logic [10:0]  mmc_group;
    logic [2:0]   wbl_shift;
    logic         wbl_ok;

    assign csd = {req_data.resp_word0, req_data.resp_word1,
                  req_data.resp_word2, req_data.resp_word3};

    assign structure    = csd[127:126];
    assign c_size_v1    = csd[73:62];
    assign c_size_mult  = csd[49:47];
    assign read_bl_len  = csd[83:80];
    assign c_size_v2    = csd[69:48];
    assign write_bl_len = csd[25:22];

    assign v1_base    = {1'b0, c_size_v1} + 13'd1;
    assign v1_shift   = {1'b0, c_size_mult} + 4'd2 + (read_bl_len - BLOCK_LEN_512);
    assign v1_sectors = (read_bl_len >= BLOCK_LEN_512) ? (33'(v1_base) << v1_shift) : 33'd0;
    assign v2_sectors = 33'({1'b0, c_size_v2} + 23'd1) << 10;

    assign speed_full = rate_exp_value(csd[98:96]) * rate_mant_value(csd[102:99]);

    assign sd_group  = {1'b0, csd[45:39]} + 8'd1;
    assign mmc_group = 11'({1'b0, csd[46:42]} + 6'd1) * 11'({1'b0, csd[41:37]} + 6'd1);
    assign wbl_ok    = write_bl_len >= BLOCK_LEN_512;
    assign wbl_shift = 3'(write_bl_len - BLOCK_LEN_512);

    always_comb
    begin
        rsp_data = '{status: ST_OK, sector_count: '0, transfer_speed: '0,
                     erase_sectors: '0, erase_valid: 1'b0};
        if (!req_data.response_received)
        begin
            rsp_data.status = ST_TIMEOUT;
        end
        else if (!req_data.long_response)
        begin
            rsp_data.status = ST_MISMATCH;
        end
        else
        begin
            if (req_data.is_mmc || structure == 2'd0)
            begin
                rsp_data.sector_count = v1_sectors;
            end
            else if (structure == 2'd1)
            begin
                rsp_data.sector_count = v2_sectors;
            end
            else
            begin
                rsp_data.status = ST_BAD_CSD;
            end

            rsp_data.transfer_speed = speed_full;

            if (!req_data.is_mmc)
            begin
                if (csd[46])
                begin
                    rsp_data.erase_sectors = 17'd1;
                    rsp_data.erase_valid   = 1'b1;
                end
                else if (wbl_ok)
                begin
                    rsp_data.erase_sectors = 17'(sd_group) << wbl_shift;
                    rsp_data.erase_valid   = 1'b1;
                end
            end
            else if (wbl_ok)
            begin
                rsp_data.erase_sectors = 17'(mmc_group) << wbl_shift;
                rsp_data.erase_valid   = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdcsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// sdcsd_out_stage
// Result register that holds a decoded result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcsd_out_stage
    import sdcsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     stage_valid,
    input  wire csd_rsp_t dec_data,
    sdcsd_rsp_if.source   rsp,
    output logic          advance
);

    logic     valid_reg;
    logic     valid_next;
    csd_rsp_t data_reg;

    assign advance = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = stage_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            data_reg <= dec_data;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.status         = data_reg.status;
    assign rsp.sector_count   = data_reg.sector_count;
    assign rsp.transfer_speed = data_reg.transfer_speed;
    assign rsp.erase_sectors  = data_reg.erase_sectors;
    assign rsp.erase_valid    = data_reg.erase_valid;

endmodule

`default_nettype wire

// ===== rtl/sd_csd_register_decoder_core.sv =====
// ----------------------------------------------------------------------------
// sd_csd_register_decoder_core
// SD/MMC CSD decoder: capacity, maximum transfer rate and erase unit.
// ----------------------------------------------------------------------------
// The block takes one CSD image per cycle unless stalled, and returns one
// result for each, in order. A request transfer is held in the input
// register, then the decode logic settles into the result register. Both
// registers advance together, so a new request is taken every cycle while
// results are taken every cycle, and a waiting result still lets one more
// request into the input register.
`default_nettype none

module sd_csd_register_decoder_core
    import sdcsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdcsd_req_if.sink   req,
    sdcsd_rsp_if.source rsp
);

`include "assert_macros.svh"

    logic     stage_valid;
    csd_req_t stage_data;
    csd_rsp_t dec_data;
    logic     advance;

    sdcsd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    sdcsd_decode u_decode (
        .req_data (stage_data),
        .rsp_data (dec_data)
    );

    sdcsd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .dec_data    (dec_data),
        .rsp         (rsp),
        .advance     (advance)
    );

    `SDC_ASSERT(a_req_captured, req.valid && req.ready |=> stage_valid,
        "Request transfer was not captured.")
    `SDC_ASSERT(a_full_stall, rsp.valid && !rsp.ready && stage_valid |-> !req.ready,
        "Request taken while the pipeline is full.")
    `SDC_ASSERT(a_no_response,
        rsp.valid && (rsp.status == ST_TIMEOUT || rsp.status == ST_MISMATCH)
        |-> rsp.sector_count == 33'd0 && rsp.transfer_speed == 30'd0 && !rsp.erase_valid,
        "Failed response carries decoded fields.")
    `SDC_ASSERT(a_erase_flag, rsp.valid && !rsp.erase_valid |-> rsp.erase_sectors == 17'd0,
        "Erase size set without its valid flag.")
    `SDC_ASSERT(a_bad_csd, rsp.valid && rsp.status == ST_BAD_CSD |-> rsp.sector_count == 33'd0,
        "Unknown structure reports a capacity.")

endmodule

`default_nettype wire
